// File: hdl/calibrated_moving_average_defines.svh
// Assertion macros shared by the calibrated moving average RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef CALIBRATED_MOVING_AVERAGE_DEFINES_SVH
`define CALIBRATED_MOVING_AVERAGE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cma_pkg.sv
// Shared types and constants for the calibrated moving average.
// No dependencies.
package cma_pkg;

  localparam int DEPTH_LOG2_DEF = 6;
  localparam int SAMPLE_W       = 24;
  localparam int GAIN_W         = 24;
  localparam int SHIFT_W        = 6;
  localparam int RESULT_W       = 48;
  localparam int DIFF_W         = SAMPLE_W + 1;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 24;
  localparam int SHIFT_MAX      = 63;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET = 2'd0,
    CFG_GAIN   = 2'd1,
    CFG_SHIFT  = 2'd2,
    CFG_FILTER = 2'd3
  } cfg_idx_t;

  // Valid flag and averaging flag of the accumulator output stage.
  typedef struct packed {
    logic valid;
    logic filt;
  } cma_ctl_t;

endpackage

// File: hdl/cma_ifs.sv
// Valid/ready stream interfaces for samples in and results out.
// Depends on cma_pkg.
interface cma_sample_if;
  import cma_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface cma_result_if;
  import cma_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] calibrated_value;

  modport source (output valid, output calibrated_value, input ready);
  modport sink   (input valid, input calibrated_value, output ready);
endinterface

// File: hdl/cma_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: hdl/cma_ring_acc.sv
// Offset subtraction, sample ring and running sum (two pipeline stages).
// Depends on cma_pkg and cma_ram.
module cma_ring_acc #(
  parameter int DEPTH_LOG2 = cma_pkg::DEPTH_LOG2_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic signed [cma_pkg::SAMPLE_W-1:0]          in_raw,
  input  logic signed [cma_pkg::SAMPLE_W-1:0]          offset,
  input  logic                                         filter_enable,
  output cma_pkg::cma_ctl_t                            acc_ctl,
  output logic signed [cma_pkg::DIFF_W+DEPTH_LOG2-1:0] acc_operand,
  input  logic                                         acc_ready
);
  import cma_pkg::*;

  localparam int SUM_W = DIFF_W + DEPTH_LOG2;

  logic [DEPTH_LOG2-1:0]     pos_r;
  logic                      full_r;
  logic                      v1_r, filt1_r, full1_r;
  logic [DEPTH_LOG2-1:0]     pos1_r;
  logic signed [DIFF_W-1:0]  diff1_r;
  logic                      v2_r, filt2_r;
  logic signed [SUM_W-1:0]   op2_r;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [DIFF_W-1:0]  diff_in;
  logic [DIFF_W-1:0]         ram_rdata;
  logic signed [DIFF_W-1:0]  oldest;
  logic                      en1, en2, accept, fire1;

  assign en2      = !v2_r || acc_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign accept   = in_valid && en1;
  assign fire1    = v1_r && en2;

  assign diff_in = DIFF_W'(in_raw) - DIFF_W'(offset);

  // Slots not yet written since reset read as zero.
  assign oldest  = full1_r ? $signed(ram_rdata) : '0;
  assign sum_nxt = sum_r - SUM_W'(oldest) + SUM_W'(diff1_r);

  // Consecutive items touch different slots; an item reads a slot only after
  // the item that wrote it left stage one, so no forwarding is needed.
  cma_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (1 << DEPTH_LOG2)
  ) u_ring (
    .clk   (clk),
    .we    (fire1 && filt1_r),
    .waddr (pos1_r),
    .wdata (diff1_r),
    .re    (accept),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      full_r <= 1'b0;
      sum_r  <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      if (accept && filter_enable) begin
        pos_r <= pos_r + 1'b1;
        if (&pos_r) begin
          full_r <= 1'b1;
        end
      end
      if (fire1 && filt1_r) begin
        sum_r <= sum_nxt;
      end
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      filt1_r <= filter_enable;
      full1_r <= full_r;
      pos1_r  <= pos_r;
      diff1_r <= diff_in;
    end
    if (fire1) begin
      filt2_r <= filt1_r;
      op2_r   <= filt1_r ? sum_nxt : SUM_W'(diff1_r);
    end
  end

  assign acc_ctl.valid = v2_r;
  assign acc_ctl.filt  = filt2_r;
  assign acc_operand   = op2_r;
endmodule

// File: hdl/cma_scale.sv
// Gain multiply, arithmetic shift, 48-bit saturation and output register.
// Depends on cma_pkg and the result stream interface.
module cma_scale #(
  parameter int DEPTH_LOG2 = cma_pkg::DEPTH_LOG2_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  cma_pkg::cma_ctl_t                            acc_ctl,
  input  logic signed [cma_pkg::DIFF_W+DEPTH_LOG2-1:0] acc_operand,
  output logic                                         acc_ready,
  input  logic signed [cma_pkg::GAIN_W-1:0]            gain,
  input  logic [cma_pkg::SHIFT_W-1:0]                  scale_shift,
  cma_result_if.source                                 out_ch
);
  import cma_pkg::*;

  localparam int SUM_W  = DIFF_W + DEPTH_LOG2;
  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int TOT_W  = SHIFT_W + 1;

  logic                      v3_r, v4_r;
  logic signed [PROD_W-1:0]  prod3_r;
  logic [SHIFT_W-1:0]        sh3_r;
  logic signed [RESULT_W-1:0] res4_r;
  logic signed [PROD_W-1:0]  prod;
  logic [TOT_W-1:0]          tot_sh;
  logic [SHIFT_W-1:0]        sh;
  logic signed [PROD_W-1:0]  shifted;
  logic [PROD_W-RESULT_W:0]  hi_bits;
  logic signed [RESULT_W-1:0] sat;
  logic                      en3, en4;

  assign en4       = !v4_r || out_ch.ready;
  assign en3       = !v3_r || en4;
  assign acc_ready = en3;

  assign prod   = PROD_W'(acc_operand) * PROD_W'(gain);
  assign tot_sh = acc_ctl.filt ? TOT_W'(scale_shift) + TOT_W'(DEPTH_LOG2)
                               : TOT_W'(scale_shift);
  assign sh     = (tot_sh > TOT_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX) : tot_sh[SHIFT_W-1:0];

  assign shifted = prod3_r >>> sh3_r;
  assign hi_bits = shifted[PROD_W-1:RESULT_W-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      sat = shifted[RESULT_W-1:0];
    end else if (shifted[PROD_W-1]) begin
      sat = {1'b1, {(RESULT_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(RESULT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en3) begin
        v3_r <= acc_ctl.valid;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_ctl.valid && en3) begin
      prod3_r <= prod;
      sh3_r   <= sh;
    end
    if (v3_r && en4) begin
      res4_r <= sat;
    end
  end

  assign out_ch.valid            = v4_r;
  assign out_ch.calibrated_value = res4_r;
endmodule

// File: hdl/calibrated_moving_average.sv
// Calibrated moving average: offset removal, boxcar average over the last
// 2^DEPTH_LOG2 differences, signed fixed-point gain, arithmetic right shift by
// scale_shift (plus DEPTH_LOG2 when averaging) and saturation to 48 bits.
// Takes one sample per clock and gives one result per sample, in order.
// A sample passes four registered stages in order: the accepting edge starts
// the ring memory read and captures the difference, then come the running-sum
// update, the multiply, and shift, saturation and the output register. The
// single read port and single write port of the ring memory set the rate at
// one sample per cycle; each stage moves up whenever the stage ahead is empty or
// moving, so the input stalls only when all four stages hold results and the
// sink holds off. The ring needs no clearing pass after reset: a fill flag
// makes slots not yet written since reset read as zero, so samples are taken
// from the first cycle after reset. Configuration registers are written
// through the cfg_ port (0 offset, 1 gain, 2 scale_shift, 3 filter_enable);
// the user must write them only while no sample is in flight, which the block
// itself does not enforce. Depends on cma_pkg, the stream interfaces,
// cma_ring_acc, cma_scale and cma_ram.
`include "calibrated_moving_average_defines.svh"

module calibrated_moving_average #(
  parameter int DEPTH_LOG2 = cma_pkg::DEPTH_LOG2_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cma_sample_if.sink                       in_ch,
  cma_result_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [cma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cma_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import cma_pkg::*;

  localparam int SUM_W = DIFF_W + DEPTH_LOG2;

  // Configuration registers.
  logic signed [SAMPLE_W-1:0] offset_r;
  logic signed [GAIN_W-1:0]   gain_r;
  logic [SHIFT_W-1:0]         shift_r;
  logic                       filt_r;

  cma_ctl_t                   acc_ctl;
  logic signed [SUM_W-1:0]    acc_operand;
  logic                       acc_ready;

  // Decode the write; unknown codes fall to the default arm and drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      gain_r   <= GAIN_W'(1);
      shift_r  <= '0;
      filt_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OFFSET: offset_r <= cfg_wdata[SAMPLE_W-1:0];
        CFG_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_SHIFT:  shift_r  <= cfg_wdata[SHIFT_W-1:0];
        CFG_FILTER: filt_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Front half: subtract offset, read the oldest slot, update the sum (or pass the difference when averaging is off).
  cma_ring_acc #(
    .DEPTH_LOG2 (DEPTH_LOG2)
  ) u_ring_acc (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_raw        (in_ch.raw_sample),
    .offset        (offset_r),
    .filter_enable (filt_r),
    .acc_ctl       (acc_ctl),
    .acc_operand   (acc_operand),
    .acc_ready     (acc_ready)
  );

  // Back half: multiply by gain, shift, saturate, hold the result beat.
  cma_scale #(
    .DEPTH_LOG2 (DEPTH_LOG2)
  ) u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_ctl     (acc_ctl),
    .acc_operand (acc_operand),
    .acc_ready   (acc_ready),
    .gain        (gain_r),
    .scale_shift (shift_r),
    .out_ch      (out_ch)
  );

  // Input backs off only when the whole pipeline is full behind a stalled sink.
  `CMA_ASSERT_NOW(a_stall_only_when_out_blocked, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled while the result side is free")
  // Hold the accumulator beat while the back half is busy.
  `CMA_ASSERT_NEXT(a_acc_holds_valid, acc_ctl.valid && !acc_ready, acc_ctl.valid, "accumulator beat dropped while stalled")
  `CMA_ASSERT_NEXT(a_acc_holds_operand, acc_ctl.valid && !acc_ready, $stable(acc_operand), "accumulator operand changed while stalled")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for calibrated_moving_average: drives sample beats,
// predicts each calibrated value and checks results in order.
// Depends on cma_pkg, the cma_sample_if/cma_result_if interfaces and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cma_pkg::*;

  localparam int     DEPTH_LOG2   = DEPTH_LOG2_DEF;
  localparam int     RING_LEN     = 1 << DEPTH_LOG2;
  // Four pipeline stages between an accepted sample and its result.
  localparam int     LATENCY      = 4;
  localparam int     HOLD_CYCLES  = 60;
  localparam int     DRAIN_LIMIT  = 2000;
  localparam int     PHASES       = 10;
  localparam int     PHASE_ITEMS  = 180;
  localparam longint OUT_HI       = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint OUT_LO       = -OUT_HI - 64'sd1;

  // Receiver behaviors between forced hold-offs.
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  cfg_idx_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  cma_sample_if sample_ch ();
  cma_result_if result_ch ();

  calibrated_moving_average #(
    .DEPTH_LOG2(DEPTH_LOG2)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (sample_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the calibration registers and the averaging state.
  logic signed [SAMPLE_W-1:0] cal_offset;
  logic signed [GAIN_W-1:0]   cal_gain;
  logic [SHIFT_W-1:0]         cal_shift;
  logic                       avg_enable;
  logic signed [DIFF_W-1:0]   diff_ring [RING_LEN];
  longint                     diff_sum;
  int unsigned                ring_slot;

  logic signed [RESULT_W-1:0] expected_values [$];
  int                         error_count;

  // Sender burst state and hold-off requests toward the receiver process.
  bit                         sender_gaps;
  int                         burst_left;
  int                         holds_requested;
  int                         holds_served;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up after a generous fixed time; a correct run ends far earlier.
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Compute the calibrated value of one accepted sample and advance the
  // shadow ring exactly as the block does.
  function automatic logic signed [RESULT_W-1:0] calibrate_sample(
    input logic signed [SAMPLE_W-1:0] raw
  );
    longint      diff;
    longint      prod;
    longint      shifted;
    int unsigned total_shift;
    diff = longint'(raw) - longint'(cal_offset);
    if (avg_enable) begin
      // Drop the overwritten entry, add the new one: the sum stays exact.
      diff_sum = diff_sum - longint'(diff_ring[ring_slot]);
      diff_ring[ring_slot] = DIFF_W'(diff);
      diff_sum = diff_sum + diff;
      ring_slot = (ring_slot + 1) % RING_LEN;
      prod = diff_sum * longint'(cal_gain);
      total_shift = cal_shift + DEPTH_LOG2;
    end else begin
      // Bypass leaves ring, sum and slot untouched.
      prod = diff * longint'(cal_gain);
      total_shift = cal_shift;
    end
    // Shifts past the word collapse to the sign: 0 or -1.
    if (total_shift > SHIFT_MAX) total_shift = SHIFT_MAX;
    shifted = prod >>> total_shift;
    if (shifted > OUT_HI) shifted = OUT_HI;
    else if (shifted < OUT_LO) shifted = OUT_LO;
    return RESULT_W'(shifted);
  endfunction

  // Pick a sample: extremes, values around zero, or anything at all.
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 24'h7F_FFFF;
      1: return 24'h80_0000;
      2: return 24'($urandom_range(0, 32)) - 24'd16;
      default: return 24'($urandom);
    endcase
  endfunction

  // Write one register; mirror it into the shadow copy the way the block
  // decodes it (only the low bits count for shift and enable).
  task automatic program_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OFFSET: cal_offset = val;
      CFG_GAIN:   cal_gain   = val;
      CFG_SHIFT:  cal_shift  = val[SHIFT_W-1:0];
      CFG_FILTER: avg_enable = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Offer one sample beat and hold it until accepted; log the prediction
  // at the accepting edge. Valid stays high on return.
  task automatic push_sample(input logic [SAMPLE_W-1:0] raw);
    sample_ch.valid      <= 1'b1;
    sample_ch.raw_sample <= raw;
    do @(posedge clk); while (!sample_ch.ready);
    expected_values.push_back(calibrate_sample(raw));
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    sample_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Send in bursts of random length; at random, insert a gap between bursts
  // when gaps are enabled.
  task automatic offer_sample(input logic [SAMPLE_W-1:0] raw);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_gaps && $urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
    burst_left--;
    push_sample(raw);
  endtask

  // Stop sending, wait for every outstanding result, then let the pipe
  // run dry. Report and drop whatever never arrives.
  task automatic settle();
    int waited;
    waited = 0;
    sample_ch.valid <= 1'b0;
    while (expected_values.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_values.size() != 0) begin
      $error("calibrated_value: %0d expected results never arrived",
             expected_values.size());
      error_count++;
      expected_values.delete();
    end
    repeat (LATENCY) @(negedge clk);
  endtask

  // Reset values straight out of reset: unity gain, no offset, averaging on.
  task automatic test_reset_defaults();
    offer_sample(24'h7F_FFFF);
    offer_sample(24'h80_0000);
    offer_sample(24'h00_0000);
    offer_sample(24'hFF_FFFF);
    offer_sample(24'h00_0001);
  endtask

  // Bypass path at the widest differences and both gain extremes.
  task automatic test_bypass_extremes();
    settle();
    // Enable bit is bit 0 only; set the rest to check they are ignored.
    program_reg(CFG_FILTER, 24'hFF_FFFE);
    program_reg(CFG_OFFSET, 24'h7F_FFFF);
    program_reg(CFG_GAIN,   24'h80_0000);
    program_reg(CFG_SHIFT,  24'h00_0000);
    offer_sample(24'h80_0000);
    offer_sample(24'h7F_FFFF);
    offer_sample(24'h00_0000);
    settle();
    program_reg(CFG_OFFSET, 24'h80_0000);
    offer_sample(24'h7F_FFFF);
    offer_sample(24'h80_0000);
    settle();
    program_reg(CFG_GAIN, 24'h7F_FFFF);
    offer_sample(24'h7F_FFFF);
  endtask

  // Shifts at and past the top of the range, averaged and not.
  task automatic test_long_shifts();
    settle();
    // Shift field is the low six bits: this writes 63.
    program_reg(CFG_SHIFT,  24'hAB_CD7F);
    program_reg(CFG_FILTER, 24'h00_0001);
    offer_sample(24'h7F_FFFF);
    offer_sample(24'h80_0000);
    settle();
    program_reg(CFG_FILTER, 24'h00_0000);
    offer_sample(24'h80_0000);
    offer_sample(24'h7F_FFFF);
    settle();
    // Averaged: 57 plus DEPTH_LOG2 (6) lands on exactly 63.
    program_reg(CFG_SHIFT,  24'd57);
    program_reg(CFG_FILTER, 24'h00_0001);
    offer_sample(24'h12_3456);
    settle();
    program_reg(CFG_SHIFT,  24'd41);
    program_reg(CFG_FILTER, 24'h00_0000);
    offer_sample(24'h80_0000);
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering beats back to back, so the pipe fills and stalls its input.
  task automatic test_output_backpressure();
    settle();
    program_reg(CFG_FILTER, 24'h00_0001);
    program_reg(CFG_SHIFT,  24'd0);
    program_reg(CFG_GAIN,   24'h00_0003);
    sender_gaps = 1'b0;
    holds_requested++;
    repeat (40) offer_sample(draw_sample());
    sender_gaps = 1'b1;
  endtask

  // Several calibration settings, extremes first, then random ones; each
  // phase streams samples with occasional runs of one value to push the
  // ring sum toward its limits.
  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0]  off_w;
    logic [CFG_DATA_W-1:0]  gain_w;
    logic [SHIFT_W-1:0]     shift_v;
    logic                   enable_v;
    logic [SAMPLE_W-1:0]    run_value;
    int                     run_left;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          off_w = 24'h7F_FFFF; gain_w = 24'h80_0000; shift_v = 6'd40; enable_v = 1'b1;
        end
        1: begin
          off_w = 24'h80_0000; gain_w = 24'h7F_FFFF; shift_v = 6'd0; enable_v = 1'b0;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: off_w = '0;
            1: off_w = 24'($urandom_range(0, 2000)) - 24'd1000;
            default: off_w = 24'($urandom);
          endcase
          case ($urandom_range(0, 3))
            0: gain_w = 24'(1 << $urandom_range(0, 22));
            1: gain_w = 24'($urandom_range(0, 128)) - 24'd64;
            2: gain_w = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
            default: gain_w = 24'($urandom);
          endcase
          if ($urandom_range(0, 1)) gain_w = -gain_w;
          shift_v  = ($urandom_range(0, 5) == 0) ? SHIFT_W'($urandom_range(41, 63))
                                                 : SHIFT_W'($urandom_range(0, 40));
          enable_v = ($urandom_range(0, 3) != 0);
        end
      endcase
      settle();
      program_reg(CFG_OFFSET, off_w);
      program_reg(CFG_GAIN,   gain_w);
      // Fill unused upper bits with noise; only the low bits are decoded.
      program_reg(CFG_SHIFT,  {18'($urandom), shift_v});
      program_reg(CFG_FILTER, {23'($urandom), enable_v});
      run_left = 0;
      run_value = '0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0 && $urandom_range(0, 15) == 0) begin
          run_left  = $urandom_range(8, 70);
          run_value = draw_sample();
        end
        if (run_left > 0) begin
          run_left--;
          offer_sample(run_value);
        end else begin
          offer_sample(draw_sample());
        end
      end
    end
  endtask

  // Receiver: random stall patterns in segments, with forced hold-offs on
  // request, counted here cycle by cycle.
  initial begin
    rx_mode_t mode;
    int       seg_left;
    int       hold_left;
    result_ch.ready = 1'b0;
    mode      = RX_OPEN;
    seg_left  = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 120);
          mode = rx_mode_t'($urandom_range(0, 3));
        end
        seg_left--;
        case (mode)
          RX_OPEN:  result_ch.ready <= 1'b1;
          RX_LIGHT: result_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HALF:  result_ch.ready <= $urandom_range(0, 1);
          default:  result_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (expected_values.size() == 0) begin
        $error("calibrated_value: no result expected, got %0d",
               result_ch.calibrated_value);
        error_count++;
      end else begin
        if (result_ch.calibrated_value !== expected_values[0]) begin
          $error("calibrated_value: expected %0d, got %0d",
                 expected_values[0], result_ch.calibrated_value);
          error_count++;
        end
        void'(expected_values.pop_front());
      end
    end
  end

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_OFFSET;
    cfg_wdata            = '0;
    sample_ch.valid      = 1'b0;
    sample_ch.raw_sample = '0;
    error_count          = 0;
    sender_gaps          = 1'b1;
    burst_left           = 0;
    holds_requested      = 0;
    holds_served         = 0;
    // Shadow state matches the block's reset.
    cal_offset = '0;
    cal_gain   = 24'sd1;
    cal_shift  = '0;
    avg_enable = 1'b1;
    diff_sum   = 0;
    ring_slot  = 0;
    foreach (diff_ring[i]) diff_ring[i] = '0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_bypass_extremes();
    test_long_shifts();
    test_output_backpressure();
    test_random_settings();
    settle();

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/cma_pkg.sv
hdl/cma_ifs.sv
hdl/cma_ram.sv
hdl/cma_ring_acc.sv
hdl/cma_scale.sv
hdl/calibrated_moving_average.sv
tb/testbench.sv
